// File: hdl/tga_rle_pixel_decoder_assert.svh
// Assertion macros for the TGA pixel decoder.
// Checks are clocked on clk and held off while rst_n is low.
`ifndef TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGARLE_ASSERT_NOW(lbl, ante, cons, msg)
`define TGARLE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/tgarle_pkg.sv
// Shared types, codes and color conversion functions for the TGA pixel decoder.
// No dependencies; used by tgarle_palette and tga_rle_pixel_decoder.
package tgarle_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 32;

  // input item kinds (in_tuser)
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  // image kinds
  localparam logic [1:0] KIND_CMAP = 2'd0;
  localparam logic [1:0] KIND_TRUE = 2'd1;
  localparam logic [1:0] KIND_MONO = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLORMAP_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 3'd4;

  localparam logic [7:0] ALPHA_FULL = 8'hff;

  typedef struct packed {
    logic        en;
    logic [7:0]  idx;
    logic [31:0] entry;
    logic [2:0]  cm_bytes;
  } pal_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
  } pal_rd_t;

  function automatic logic [2:0] clamp_size(input logic [2:0] n);
    if (n == 3'd0) begin
      return 3'd1;
    end
    if (n > 3'd4) begin
      return 3'd4;
    end
    return n;
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [31:0] from1555(input logic [15:0] v);
    logic [7:0] a;
    a = v[15] ? ALPHA_FULL : 8'h00;
    return {a, widen5(v[14:10]), widen5(v[9:5]), widen5(v[4:0])};
  endfunction

  function automatic logic [31:0] grey(input logic [7:0] v);
    return {ALPHA_FULL, v, v, v};
  endfunction

  // palette entry to BGRA word
  function automatic logic [31:0] cmap_convert(input logic [31:0] entry,
                                               input logic [2:0]  cm_bytes);
    logic [2:0]  cb;
    logic [31:0] w;
    cb = clamp_size(cm_bytes);
    case (cb)
      3'd1:    w = grey(entry[7:0]);
      3'd2:    w = from1555(entry[15:0]);
      3'd3:    w = {ALPHA_FULL, entry[23:0]};
      default: w = entry;
    endcase
    return w;
  endfunction

  // gathered pixel to BGRA word; nb is already clamped
  function automatic logic [31:0] pix_convert(input logic [1:0]  kind,
                                              input logic [2:0]  nb,
                                              input logic [31:0] value,
                                              input logic [31:0] pal_word);
    logic [31:0] w;
    if (kind == KIND_CMAP) begin
      w = {ALPHA_FULL, pal_word[23:0]};
    end else if (kind == KIND_MONO || nb == 3'd1) begin
      w = grey(value[7:0]);
    end else if (nb == 3'd2) begin
      w = from1555(value[15:0]);
    end else if (nb == 3'd3) begin
      w = {ALPHA_FULL, value[23:0]};
    end else begin
      w = value;
    end
    return w;
  endfunction

endpackage

// File: hdl/tgarle_palette.sv
// Palette store: converts palette entries to BGRA and keeps them in a memory.
// Valid bits clear at reset so unwritten slots read as zero. Uses tgarle_pkg.
module tgarle_palette #(
  parameter int PALETTE_DEPTH = tgarle_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tgarle_pkg::pal_wr_t wr,
  input  tgarle_pkg::pal_rd_t rd,
  output logic [31:0]         rd_word
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [31:0]              palette_mem [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] valid_r;
  logic [PALETTE_DEPTH-1:0] valid_nxt;
  logic [31:0]              rd_q_r;
  logic                     rd_ok_r;
  logic                     rd_ok_nxt;
  logic                     wr_in_range;
  logic                     rd_in_range;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;

  assign wr_in_range = {1'b0, wr.idx} < 9'(PALETTE_DEPTH);
  assign rd_in_range = {1'b0, rd.idx} < 9'(PALETTE_DEPTH);
  assign wr_addr     = wr.idx[AW-1:0];
  assign rd_addr     = rd.idx[AW-1:0];

  always_comb begin
    valid_nxt = valid_r;
    if (wr.en && wr_in_range) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    rd_ok_nxt = rd_ok_r;
    if (rd.en) begin
      rd_ok_nxt = valid_r[rd_addr] && rd_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      palette_mem[wr_addr] <= tgarle_pkg::cmap_convert(wr.entry, wr.cm_bytes);
    end
  end

  // hold read data while the stage behind is stalled
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q_r <= palette_mem[rd_addr];
    end
  end

  assign rd_word = rd_ok_r ? rd_q_r : 32'd0;

endmodule

// File: hdl/tga_rle_pixel_decoder.sv
// TGA image-data decoder top level: packet parsing, pixel gathering, output stage.
// Depends on tgarle_pkg, tgarle_palette and tga_rle_pixel_decoder_assert.svh.
//
//  channel   direction  handshake           payload
//  in_       slave      tvalid/tready       tuser: cmd; tdata: byte, slot, entry
//  out_      master     tvalid/tready/tlast tdata: color, first, repeat; tuser: bad
//  cfg_      write      cfg_we              cfg_index, cfg_wdata
//
// One input byte or palette item is taken per cycle while the middle stage can load;
// the byte that completes a pixel is registered with its palette read, then in the
// output register. Rate is set by the single palette read port: one lookup a cycle.
// Reset clears stream state and the palette valid bits.
// A stalled output holds; input keeps flowing while the middle stage is free.
`include "tga_rle_pixel_decoder_assert.svh"

module tga_rle_pixel_decoder #(
  parameter int PALETTE_DEPTH = tgarle_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,  // data_byte, palette_index, palette_entry
  input  logic                             in_tuser,  // cmd
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [71:0]                      out_tdata, // color, first_pixel, repeat_count
  output logic                             out_tlast,
  output logic                             out_tuser, // bad_packet
  input  logic                             cfg_we,
  input  logic [tgarle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration
  logic [1:0]  image_kind_r;
  logic        rle_enable_r;
  logic [2:0]  pixel_bytes_r;
  logic [2:0]  colormap_bytes_r;
  logic [31:0] pixel_count_r;

  // stream state
  logic [31:0] pos_r, pos_nxt;
  logic [7:0]  pk_left_r, pk_left_nxt;
  logic        pk_run_r, pk_run_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [1:0]  slot_r, slot_nxt;
  logic        err_r, err_nxt;

  // middle stage
  logic        s2_valid_r, s2_valid_nxt;
  logic [31:0] s2_value_r;
  logic [31:0] s2_first_r;
  logic [7:0]  s2_repeat_r;
  logic        s2_last_r;
  logic        s2_bad_r;

  // output stage
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_color_r;
  logic [31:0] out_first_r;
  logic [7:0]  out_repeat_r;
  logic        out_last_r;
  logic        out_bad_r;

  logic        out_ld;
  logic        s2_ld;
  logic        accept;
  logic        is_pix;
  logic [7:0]  in_byte;
  logic [2:0]  nb;
  logic        done;
  logic [31:0] remaining;
  logic [7:0]  run_len;
  logic [31:0] value;
  logic [7:0]  rep;
  logic        produce;
  logic        last;
  logic [31:0] pal_word;

  tgarle_pkg::pal_wr_t pal_wr;
  tgarle_pkg::pal_rd_t pal_rd;

  assign out_ld    = !out_valid_r || out_tready;
  assign s2_ld     = !s2_valid_r || out_ld;
  assign in_tready = s2_ld;
  assign accept    = in_tvalid && in_tready;
  assign is_pix    = accept && (in_tuser == tgarle_pkg::CMD_PIXEL);
  assign in_byte   = in_tdata[7:0];
  assign nb        = tgarle_pkg::clamp_size(pixel_bytes_r);
  assign done      = pos_r >= pixel_count_r;
  assign remaining = pixel_count_r - pos_r;
  assign run_len   = {1'b0, in_byte[6:0]} + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_kind_r     <= tgarle_pkg::KIND_TRUE;
      rle_enable_r     <= 1'b0;
      pixel_bytes_r    <= 3'd4;
      colormap_bytes_r <= 3'd3;
      pixel_count_r    <= 32'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::REG_IMAGE_KIND:     image_kind_r     <= cfg_wdata[1:0];
        tgarle_pkg::REG_RLE_ENABLE:     rle_enable_r     <= cfg_wdata[0];
        tgarle_pkg::REG_PIXEL_BYTES:    pixel_bytes_r    <= cfg_wdata[2:0];
        tgarle_pkg::REG_COLORMAP_BYTES: colormap_bytes_r <= cfg_wdata[2:0];
        tgarle_pkg::REG_PIXEL_COUNT:    pixel_count_r    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // packet parse and pixel gather
  always_comb begin
    pos_nxt     = pos_r;
    pk_left_nxt = pk_left_r;
    pk_run_nxt  = pk_run_r;
    gather_nxt  = gather_r;
    slot_nxt    = slot_r;
    err_nxt     = err_r;
    value       = {8'd0, gather_r} | ({24'd0, in_byte} << {slot_r, 3'b000});
    rep         = 8'd1;
    produce     = 1'b0;
    last        = 1'b0;
    if (is_pix && !done) begin
      if (rle_enable_r && pk_left_r == 8'd0) begin
        // packet header: clip a packet that runs past the image
        if ({24'd0, run_len} > remaining) begin
          err_nxt     = 1'b1;
          pk_left_nxt = remaining[7:0];
        end else begin
          pk_left_nxt = run_len;
        end
        pk_run_nxt = in_byte[7];
        gather_nxt = 24'd0;
        slot_nxt   = 2'd0;
      end else if ({1'b0, slot_r} + 3'd1 < nb) begin
        case (slot_r)
          2'd0:    gather_nxt[7:0]   = gather_r[7:0] | in_byte;
          2'd1:    gather_nxt[15:8]  = gather_r[15:8] | in_byte;
          default: gather_nxt[23:16] = gather_r[23:16] | in_byte;
        endcase
        slot_nxt = slot_r + 2'd1;
      end else begin
        gather_nxt = 24'd0;
        slot_nxt   = 2'd0;
        if (rle_enable_r && pk_run_r) begin
          rep         = pk_left_r;
          pk_left_nxt = 8'd0;
        end else if (rle_enable_r) begin
          pk_left_nxt = pk_left_r - 8'd1;
        end
        if ({24'd0, rep} > remaining) begin
          rep = remaining[7:0];
        end
        pos_nxt = pos_r + {24'd0, rep};
        produce = 1'b1;
        last    = pos_nxt == pixel_count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 32'd0;
      pk_left_r <= 8'd0;
      pk_run_r  <= 1'b0;
      gather_r  <= 24'd0;
      slot_r    <= 2'd0;
      err_r     <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      pk_left_r <= pk_left_nxt;
      pk_run_r  <= pk_run_nxt;
      gather_r  <= gather_nxt;
      slot_r    <= slot_nxt;
      err_r     <= err_nxt;
    end
  end

  always_comb begin
    pal_wr.en       = accept && (in_tuser == tgarle_pkg::CMD_PALETTE);
    pal_wr.idx      = in_tdata[15:8];
    pal_wr.entry    = in_tdata[47:16];
    pal_wr.cm_bytes = colormap_bytes_r;
    pal_rd.en       = s2_ld;
    pal_rd.idx      = value[7:0];
  end

  tgarle_palette #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (pal_wr),
    .rd     (pal_rd),
    .rd_word(pal_word)
  );

  // stage valids: drop items that complete no pixel
  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_ld) begin
      s2_valid_nxt = produce;
    end
    out_valid_nxt = out_valid_r;
    if (out_ld) begin
      out_valid_nxt = s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ld) begin
      s2_value_r  <= value;
      s2_first_r  <= pos_r;
      s2_repeat_r <= rep;
      s2_last_r   <= last;
      s2_bad_r    <= err_r;
    end
    if (out_ld) begin
      out_color_r  <= tgarle_pkg::pix_convert(image_kind_r, nb, s2_value_r, pal_word);
      out_first_r  <= s2_first_r;
      out_repeat_r <= s2_repeat_r;
      out_last_r   <= s2_last_r;
      out_bad_r    <= s2_bad_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_repeat_r, out_first_r, out_color_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_bad_r;

  `TGARLE_ASSERT_NEXT(a_err_sticky, err_r, err_r, "packet error flag cleared")
  `TGARLE_ASSERT_NOW(a_pk_left_max, 1'b1, pk_left_r <= 8'd128, "packet count above 128")
  `TGARLE_ASSERT_NOW(a_rep_nonzero, out_valid_r, out_repeat_r != 8'd0, "zero repeat count")
  `TGARLE_ASSERT_NOW(a_last_ends, out_valid_r && out_last_r,
                     (out_first_r + {24'd0, out_repeat_r}) == pixel_count_r,
                     "last result does not end image")

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the TGA image-data pixel decoder: palette loads and image
// bytes go in over the input stream, each pixel result is checked against a local
// decoder model or a directed expectation. Needs tgarle_pkg and the tga_rle_pixel_decoder RTL.
module testbench;

  localparam int          ITEM_BUDGET   = 1600;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          NUM_DIRECTED  = 38;
  localparam logic [31:0] MAX_PIXELS    = 32'd4294836225;
  localparam logic [1:0]  KIND_ODD      = 2'd3;  // unused code, decoded as truecolor

  typedef struct packed {
    logic [31:0] color;
    logic [31:0] first;
    logic [7:0]  reps;
    logic        last;
    logic        bad;
  } pix_run_t;

  localparam pix_run_t NO_RUN = '0;

  typedef enum logic [1:0] {ROW_CFG, ROW_PAL, ROW_PIX} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [7:0]  a;      // register index or palette slot
    logic [31:0] v;      // register value, palette entry or data byte
    logic        typed;
    pix_run_t    want;
  } dir_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [47:0]                       in_tdata;   // data_byte, palette_index, palette_entry
  logic                              in_tuser;   // cmd
  logic                              out_tvalid;
  logic                              out_tready;
  logic [71:0]                       out_tdata;  // color, first_pixel, repeat_count
  logic                              out_tlast;
  logic                              out_tuser;  // bad_packet
  logic                              cfg_we;
  logic [tgarle_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_wdata;

  tga_rle_pixel_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // decoder model state
  logic [1:0]  r_kind;
  logic        r_rle;
  logic [2:0]  r_pb;
  logic [2:0]  r_cb;
  logic [31:0] r_count;
  logic [31:0] palette [256];
  logic [31:0] pix_pos;
  logic [7:0]  pk_left;
  logic        pk_run;
  logic [23:0] gather;
  logic [1:0]  gslot;
  logic        err_seen;

  pix_run_t pending_runs [$];
  dir_row_t dir_rows [NUM_DIRECTED];
  int       errors;
  int       items_taken;
  int       results_seen;
  int       settings_used;
  bit       no_gaps;

  function automatic logic [2:0] fit_size(input logic [2:0] n);
    if (n == 3'd0) return 3'd1;
    return (n > 3'd4) ? 3'd4 : n;
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, 3'b000} | {5'b00000, v[4:2]};
  endfunction

  function automatic logic [31:0] argb1555(input logic [15:0] v);
    return {{8{v[15]}}, expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0])};
  endfunction

  function automatic logic [31:0] grey_word(input logic [7:0] v);
    return {tgarle_pkg::ALPHA_FULL, v, v, v};
  endfunction

  function automatic logic [31:0] palette_word(input logic [31:0] entry,
                                               input logic [2:0]  size);
    case (fit_size(size))
      3'd1:    return grey_word(entry[7:0]);
      3'd2:    return argb1555(entry[15:0]);
      3'd3:    return {tgarle_pkg::ALPHA_FULL, entry[23:0]};
      default: return entry;
    endcase
  endfunction

  // Advance the model by one transfer; took is low when the byte is ignored.
  function automatic void decode_item(input logic cmd, input logic [7:0] b,
                                      input logic [7:0] sl, input logic [31:0] entry,
                                      output bit took, output bit made,
                                      output pix_run_t run);
    logic [2:0]  nb;
    logic [31:0] remain;
    logic [31:0] reps;
    logic [31:0] value;
    logic [31:0] word;
    took = 1'b0;
    made = 1'b0;
    run  = NO_RUN;
    if (cmd == tgarle_pkg::CMD_PALETTE) begin
      palette[sl] = palette_word(entry, r_cb);
      took = 1'b1;
      return;
    end
    if (pix_pos >= r_count) return;
    took   = 1'b1;
    remain = r_count - pix_pos;
    if (r_rle && pk_left == 8'd0) begin
      reps = {25'd0, b[6:0]} + 32'd1;
      // clip a packet that runs past the image and flag it for good
      if (reps > remain) begin
        err_seen = 1'b1;
        reps     = remain;
      end
      pk_left = reps[7:0];
      pk_run  = b[7];
      gather  = '0;
      gslot   = '0;
      return;
    end
    nb = fit_size(r_pb);
    if (({1'b0, gslot} + 3'd1) < nb) begin
      gather = gather | ({16'd0, b} << (8 * gslot));
      gslot  = gslot + 2'd1;
      return;
    end
    value  = {8'd0, gather} | ({24'd0, b} << (8 * gslot));
    gather = '0;
    gslot  = '0;
    if (r_kind == tgarle_pkg::KIND_CMAP) begin
      word = {tgarle_pkg::ALPHA_FULL, palette[value[7:0]][23:0]};
    end else if (r_kind == tgarle_pkg::KIND_MONO || nb == 3'd1) begin
      word = grey_word(value[7:0]);
    end else if (nb == 3'd2) begin
      word = argb1555(value[15:0]);
    end else if (nb == 3'd3) begin
      word = {tgarle_pkg::ALPHA_FULL, value[23:0]};
    end else begin
      word = value;
    end
    run.first = pix_pos;
    if (r_rle && pk_run) begin
      reps    = {24'd0, pk_left};
      pk_left = 8'd0;
    end else begin
      reps = 32'd1;
      if (r_rle) pk_left = pk_left - 8'd1;
    end
    if (reps > remain) reps = remain;
    pix_pos   = pix_pos + reps;
    run.color = word;
    run.reps  = reps[7:0];
    run.last  = (pix_pos == r_count);
    run.bad   = err_seen;
    made      = 1'b1;
  endfunction

  task automatic push_item(input logic cmd, input logic [7:0] b, input logic [7:0] sl,
                           input logic [31:0] entry, input bit typed,
                           input pix_run_t want);
    bit       took;
    bit       made;
    pix_run_t run;
    while (!no_gaps && $urandom_range(0, 99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {entry, sl, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_item(cmd, b, sl, entry, took, made, run);
    if (took) items_taken++;
    if (made) pending_runs.push_back(typed ? want : run);
  endtask

  task automatic send_byte(input logic [7:0] b);
    push_item(tgarle_pkg::CMD_PIXEL, b, 8'($urandom_range(0, 255)), $urandom, 1'b0,
              NO_RUN);
  endtask

  task automatic send_palette();
    push_item(tgarle_pkg::CMD_PALETTE, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), $urandom, 1'b0, NO_RUN);
  endtask

  // One well-formed packet (or one pixel without RLE) with random content.
  task automatic send_packet();
    logic [7:0] hdr;
    logic [2:0] nb;
    int         npix;
    nb   = fit_size(r_pb);
    npix = 1;
    if (r_rle) begin
      hdr = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 7) hdr[6:0] = 7'($urandom_range(0, 7));
      send_byte(hdr);
      npix = hdr[7] ? 1 : int'(hdr[6:0]) + 1;
    end
    repeat (npix * int'(nb)) begin
      if ($urandom_range(0, 9) == 0) send_palette();
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Registers change only once the decoder has gone quiet.
  task automatic write_reg(input logic [tgarle_pkg::CFG_IDX_W-1:0] sel,
                           input logic [31:0] val);
    in_tvalid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      tgarle_pkg::REG_IMAGE_KIND:     r_kind  = val[1:0];
      tgarle_pkg::REG_RLE_ENABLE:     r_rle   = val[0];
      tgarle_pkg::REG_PIXEL_BYTES:    r_pb    = val[2:0];
      tgarle_pkg::REG_COLORMAP_BYTES: r_cb    = val[2:0];
      tgarle_pkg::REG_PIXEL_COUNT:    r_count = val;
      default: ;
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 35);
  end

  always @(posedge clk) begin : check_results
    pix_run_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_runs.size() == 0) begin
        $error("pixel result with nothing expected: color %h first %0d",
               out_tdata[31:0], out_tdata[63:32]);
        errors++;
      end else begin
        want = pending_runs.pop_front();
        results_seen++;
        if (out_tdata[31:0] !== want.color) begin
          $error("color: expected %h, got %h", want.color, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== want.first) begin
          $error("first_pixel: expected %0d, got %0d", want.first, out_tdata[63:32]);
          errors++;
        end
        if (out_tdata[71:64] !== want.reps) begin
          $error("repeat_count: expected %0d, got %0d", want.reps, out_tdata[71:64]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_image: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
        if (out_tuser !== want.bad) begin
          $error("bad_packet: expected %b, got %b", want.bad, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [1:0]  kind;
    logic [2:0]  pbytes;
    logic [2:0]  cbytes;
    logic [31:0] total;
    int          sel;
    int          wait_cnt;

    in_tvalid  <= 1'b0;
    in_tuser   <= tgarle_pkg::CMD_PIXEL;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;

    r_kind   = tgarle_pkg::KIND_TRUE;
    r_rle    = 1'b0;
    r_pb     = 3'd4;
    r_cb     = 3'd3;
    r_count  = 32'd1;
    pix_pos  = '0;
    pk_left  = '0;
    pk_run   = 1'b0;
    gather   = '0;
    gslot    = '0;
    err_seen = 1'b0;
    for (int i = 0; i < 256; i++) palette[i] = '0;
    errors        = 0;
    items_taken   = 0;
    results_seen  = 0;
    settings_used = 0;
    no_gaps       = 1'b0;

    dir_rows = '{
      // reset setting: one 4-byte truecolor pixel, then a byte past the end
      '{ROW_PIX, 8'h00, 32'h44, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h33, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h22, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h11, 1'b1, '{32'h11223344, 32'd0, 8'd1, 1'b1, 1'b0}},
      '{ROW_PIX, 8'h00, 32'hab, 1'b0, NO_RUN},
      // palette loads under every entry size, out-of-range sizes included
      '{ROW_PAL, 8'd0, 32'hffffffff, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_COLORMAP_BYTES), 32'd1, 1'b0, NO_RUN},
      '{ROW_PAL, 8'd1, 32'h000000a5, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_COLORMAP_BYTES), 32'd2, 1'b0, NO_RUN},
      '{ROW_PAL, 8'd2, 32'h00008000, 1'b0, NO_RUN},
      '{ROW_PAL, 8'd3, 32'h00007fff, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_COLORMAP_BYTES), 32'd0, 1'b0, NO_RUN},
      '{ROW_PAL, 8'd4, 32'hffffff00, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_COLORMAP_BYTES), 32'd7, 1'b0, NO_RUN},
      '{ROW_PAL, 8'd255, 32'h80000001, 1'b0, NO_RUN},
      // indexed pixels looking up those slots
      '{ROW_CFG, 8'(tgarle_pkg::REG_IMAGE_KIND), 32'(tgarle_pkg::KIND_CMAP), 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_BYTES), 32'd1, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_COUNT), 32'd6, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h00, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h01, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h02, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h03, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'hff, 1'b0, NO_RUN},
      // unused kind code decodes as truecolor 1555
      '{ROW_CFG, 8'(tgarle_pkg::REG_IMAGE_KIND), 32'(KIND_ODD), 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_BYTES), 32'd2, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_COUNT), 32'd7, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'hff, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'hff, 1'b1, '{32'hffffffff, 32'd6, 8'd1, 1'b1, 1'b0}},
      // empty image swallows data
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_COUNT), 32'd0, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h12, 1'b0, NO_RUN},
      // RLE, one-byte truecolor as grey, then a packet past the end
      '{ROW_CFG, 8'(tgarle_pkg::REG_IMAGE_KIND), 32'(tgarle_pkg::KIND_TRUE), 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_BYTES), 32'd1, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_RLE_ENABLE), 32'd1, 1'b0, NO_RUN},
      '{ROW_CFG, 8'(tgarle_pkg::REG_PIXEL_COUNT), 32'd10, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h81, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'h00, 1'b1, '{32'hff000000, 32'd7, 8'd2, 1'b0, 1'b0}},
      '{ROW_PIX, 8'h00, 32'h7f, 1'b0, NO_RUN},
      '{ROW_PIX, 8'h00, 32'hff, 1'b1, '{32'hffffffff, 32'd9, 8'd1, 1'b1, 1'b1}}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      case (dir_rows[i].op)
        ROW_CFG: write_reg(dir_rows[i].a[tgarle_pkg::CFG_IDX_W-1:0], dir_rows[i].v);
        ROW_PAL: push_item(tgarle_pkg::CMD_PALETTE, 8'h00, dir_rows[i].a, dir_rows[i].v,
                           1'b0, NO_RUN);
        default: push_item(tgarle_pkg::CMD_PIXEL, dir_rows[i].v[7:0], 8'h00, 32'h0,
                           dir_rows[i].typed, dir_rows[i].want);
      endcase
    end

    // random image settings, each fed well-formed packets plus some noise
    while (items_taken < ITEM_BUDGET) begin
      sel  = $urandom_range(0, 15);
      kind = (sel < 5)  ? tgarle_pkg::KIND_CMAP :
             (sel < 10) ? tgarle_pkg::KIND_TRUE :
             (sel < 14) ? tgarle_pkg::KIND_MONO : KIND_ODD;
      if ($urandom_range(0, 9) < 8) begin
        pbytes = (kind == tgarle_pkg::KIND_CMAP || kind == tgarle_pkg::KIND_MONO)
                 ? 3'd1 : 3'($urandom_range(1, 4));
      end else begin
        pbytes = 3'($urandom_range(0, 7));
      end
      cbytes = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                          : 3'($urandom_range(0, 7));
      sel   = $urandom_range(0, 29);
      total = (sel == 0) ? 32'd0 : (sel == 1) ? MAX_PIXELS
                                              : pix_pos + 32'($urandom_range(1, 48));
      write_reg(tgarle_pkg::REG_IMAGE_KIND, {30'd0, kind});
      write_reg(tgarle_pkg::REG_RLE_ENABLE, 32'($urandom_range(0, 1)));
      write_reg(tgarle_pkg::REG_PIXEL_BYTES, {29'd0, pbytes});
      write_reg(tgarle_pkg::REG_COLORMAP_BYTES, {29'd0, cbytes});
      write_reg(tgarle_pkg::REG_PIXEL_COUNT, total);
      settings_used++;
      for (int p = 0; p < 64 && pix_pos < r_count && items_taken < ITEM_BUDGET; p++) begin
        no_gaps = (items_taken >= 700 && items_taken < 1000);
        case ($urandom_range(0, 11))
          0:       send_byte(8'($urandom_range(0, 255)));
          1:       send_palette();
          default: send_packet();
        endcase
      end
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
    end

    in_tvalid <= 1'b0;
    no_gaps = 1'b0;
    for (wait_cnt = 0; pending_runs.size() != 0 && wait_cnt < 10000; wait_cnt++) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_runs.size() != 0) begin
      $error("%0d pixel results never arrived", pending_runs.size());
      errors++;
    end
    $display("fed %0d decoded transfers under %0d image settings, compared %0d results",
             items_taken, settings_used + 6, results_seen);
    $display("last pixel position %0d, overrun flag %b", pix_pos, err_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
